// ----- sv/tnbt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tnbt_pkg: shared types and constants of the timed name block table
// Holds the transaction structs, the slot row layout and the byte mask helper.
// ----------------------------------------------------------------------------
package tnbt_pkg;

    localparam int          TABLE_SLOTS_DEF = 10;
    localparam int          NAME_MAX_BYTES  = 32;
    localparam logic [15:0] TIMEOUT_RESET   = 16'd60;

    localparam logic [1:0] CODE_FREE     = 2'd0;
    localparam logic [1:0] CODE_BLOCKED  = 2'd1;
    localparam logic [1:0] CODE_INSERTED = 2'd2;
    localparam logic [1:0] CODE_FULL     = 2'd3;

    typedef struct packed {
        logic [31:0] now_seconds;
        logic [5:0]  name_length;
        logic [63:0] name_bytes_24_31;
        logic [63:0] name_bytes_16_23;
        logic [63:0] name_bytes_8_15;
        logic [63:0] name_bytes_0_7;
        logic        op;
    } t_in_item;

    typedef struct packed {
        logic [1:0] result_code;
        logic [3:0] slot_index;
    } t_out_item;

    typedef struct packed {
        logic [255:0] name;
        logic [5:0]   len;
        logic [31:0]  expiry;
    } t_slot_row;

    typedef struct packed {
        logic expired;
        logic same;
    } t_match;

    function automatic logic [255:0] byte_mask(input logic [5:0] len);
        logic [255:0] m;
        m = '0;
        for (int i = 0; i < NAME_MAX_BYTES; i++) begin
            m[i*8 +: 8] = {8{6'(i) < len}};
        end
        return m;
    endfunction

endpackage

// ----- sv/tnbt_slot_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tnbt_slot_ram: slot storage
// One row per slot with name bytes, length and expiry; registered read port.
// ----------------------------------------------------------------------------
module tnbt_slot_ram #(
    parameter int DEPTH = tnbt_pkg::TABLE_SLOTS_DEF,
    parameter int AW    = 4
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [AW-1:0]        i_waddr,
    input  tnbt_pkg::t_slot_row  i_wdata,
    input  logic                 i_re,
    input  logic [AW-1:0]        i_raddr,
    output tnbt_pkg::t_slot_row  o_rdata
);
    import tnbt_pkg::*;

    t_slot_row r_mem [DEPTH];
    t_slot_row r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/tnbt_match.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tnbt_match: slot compare unit
// Checks one stored row against the looked-up name and the current time.
// ----------------------------------------------------------------------------
module tnbt_match (
    input  tnbt_pkg::t_slot_row i_row,
    input  logic [255:0]        i_name,
    input  logic [5:0]          i_len,
    input  logic [31:0]         i_now,
    output tnbt_pkg::t_match    o_match
);
    import tnbt_pkg::*;

    logic [255:0] mask;

    assign mask = byte_mask(i_len);

    always_comb begin
        o_match.expired = (i_row.expiry <= i_now);
        o_match.same    = (i_len <= 6'(NAME_MAX_BYTES)) && (i_row.len == i_len) &&
                          ((i_row.name & mask) == (i_name & mask));
    end

endmodule

// ----- sv/timed_name_block_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timed_name_block_table: table of blocked names with expiry times
// A transaction is taken when start is high and busy is low. An insert walks
// the slot occupancy flags one slot per cycle and writes the first empty slot.
// A lookup reads one slot row per cycle from the slot memory and checks it in
// the compare unit; the lookup also purges the expired slots that it checks.
// Busy stays high for the whole walk.
// The result appears on o_result for exactly one cycle with o_result_valid
// high; the receiver cannot stall, and the next start can be taken in that
// same cycle. The timeout register is written whenever i_cfg_we is high.
// Reset clears the occupancy flags, so every slot reads as empty at once with
// no clearing pass, and sets the timeout back to 60 seconds.
// ----------------------------------------------------------------------------
module timed_name_block_table #(
    parameter int TABLE_SLOTS = tnbt_pkg::TABLE_SLOTS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  tnbt_pkg::t_in_item  i_cmd,
    output logic                o_result_valid,
    output tnbt_pkg::t_out_item o_result,
    input  logic                i_cfg_we,
    input  logic [15:0]         i_cfg_wdata
);
    import tnbt_pkg::*;

    localparam int SW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int CW = $clog2(TABLE_SLOTS + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_INS  = 2'd1;
    localparam logic [1:0] S_LOOK = 2'd2;

    logic [1:0]             r_state,   n_state;
    logic [CW-1:0]          r_slot,    n_slot;
    logic                   r_cmp_vld, n_cmp_vld;
    logic [CW-1:0]          r_cmp_slot, n_cmp_slot;
    logic [TABLE_SLOTS-1:0] r_occ,     n_occ;
    logic                   r_res_vld, n_res_vld;
    t_out_item              r_res,     n_res;
    t_in_item               r_item;
    logic [15:0]            r_timeout;

    logic [255:0] name;
    logic [5:0]   slen;
    logic [SW-1:0] slot_idx;
    logic [SW-1:0] cmp_idx;
    logic         mem_we;
    logic         mem_re;
    t_slot_row    wr_row;
    t_slot_row    rd_row;
    t_match       match;

    assign name     = {r_item.name_bytes_24_31, r_item.name_bytes_16_23,
                       r_item.name_bytes_8_15, r_item.name_bytes_0_7};
    assign slen     = (r_item.name_length > 6'(NAME_MAX_BYTES)) ?
                      6'(NAME_MAX_BYTES) : r_item.name_length;
    assign slot_idx = r_slot[SW-1:0];
    assign cmp_idx  = r_cmp_slot[SW-1:0];

    always_comb begin
        wr_row.name   = name & byte_mask(slen);
        wr_row.len    = slen;
        wr_row.expiry = r_item.now_seconds + {16'd0, r_timeout};
    end

    tnbt_slot_ram #(
        .DEPTH (TABLE_SLOTS),
        .AW    (SW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (slot_idx),
        .i_wdata (wr_row),
        .i_re    (mem_re),
        .i_raddr (slot_idx),
        .o_rdata (rd_row)
    );

    tnbt_match u_match (
        .i_row   (rd_row),
        .i_name  (name),
        .i_len   (r_item.name_length),
        .i_now   (r_item.now_seconds),
        .o_match (match)
    );

    always_comb begin
        n_state    = r_state;
        n_slot     = r_slot;
        n_cmp_vld  = r_cmp_vld;
        n_cmp_slot = r_cmp_slot;
        n_occ      = r_occ;
        n_res_vld  = 1'b0;
        n_res      = r_res;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_slot    = '0;
                    n_cmp_vld = 1'b0;
                    n_state   = i_cmd.op ? S_INS : S_LOOK;
                end
            end
            S_INS: begin
                if (!r_occ[slot_idx]) begin
                    mem_we           = 1'b1;
                    n_occ[slot_idx]  = (slen != 6'd0) && (name[7:0] != 8'd0);
                    n_res.result_code = CODE_INSERTED;
                    n_res.slot_index  = 4'(slot_idx);
                    n_res_vld        = 1'b1;
                    n_state          = S_IDLE;
                end else if (r_slot == CW'(TABLE_SLOTS - 1)) begin
                    n_res.result_code = CODE_FULL;
                    n_res.slot_index  = 4'd0;
                    n_res_vld        = 1'b1;
                    n_state          = S_IDLE;
                end else begin
                    n_slot = r_slot + 1'b1;
                end
            end
            S_LOOK: begin
                mem_re     = (r_slot < CW'(TABLE_SLOTS));
                n_cmp_vld  = mem_re;
                n_cmp_slot = r_slot;
                if (mem_re) begin
                    n_slot = r_slot + 1'b1;
                end
                if (r_cmp_vld) begin
                    if (r_occ[cmp_idx] && match.expired) begin
                        n_occ[cmp_idx] = 1'b0;
                    end
                    if (r_occ[cmp_idx] && !match.expired && match.same) begin
                        n_res.result_code = CODE_BLOCKED;
                        n_res.slot_index  = 4'(cmp_idx);
                        n_res_vld        = 1'b1;
                        n_state          = S_IDLE;
                    end else if (r_cmp_slot == CW'(TABLE_SLOTS - 1)) begin
                        n_res.result_code = CODE_FREE;
                        n_res.slot_index  = 4'd0;
                        n_res_vld        = 1'b1;
                        n_state          = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_slot    <= '0;
            r_cmp_vld <= 1'b0;
            r_cmp_slot <= '0;
            r_occ     <= '0;
            r_res_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_slot    <= n_slot;
            r_cmp_vld <= n_cmp_vld;
            r_cmp_slot <= n_cmp_slot;
            r_occ     <= n_occ;
            r_res_vld <= n_res_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        if (start && !busy) begin
            r_item <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_RESET;
        end else if (i_cfg_we) begin
            r_timeout <= i_cfg_wdata;
        end
    end

    assign busy           = (r_state != S_IDLE);
    assign o_result_valid = r_res_vld;
    assign o_result       = r_res;

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench of the timed name block table
// Drives insert and lookup transactions through the start/busy handshake and
// keeps its own copy of the slot table to predict each verdict. Directed tests
// cover the corner cases of names, lengths, expiry and timeout. Random traffic
// replays a small set of names under several timeouts and sender idle rates.
// ----------------------------------------------------------------------------
module tb;
    import tnbt_pkg::*;

    localparam int   TABLE_SLOTS = TABLE_SLOTS_DEF;
    localparam int   POOL_SIZE   = 12;
    localparam int   CYCLE_LIMIT = 500000;
    localparam logic OP_LOOKUP   = 1'b0;
    localparam logic OP_INSERT   = 1'b1;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        start       = 1'b0;
    logic        busy;
    t_in_item    i_cmd       = '0;
    logic        o_result_valid;
    t_out_item   o_result;
    logic        i_cfg_we    = 1'b0;
    logic [15:0] i_cfg_wdata = '0;

    logic [255:0] slot_name   [TABLE_SLOTS];
    logic [5:0]   slot_len    [TABLE_SLOTS];
    logic [31:0]  slot_expiry [TABLE_SLOTS];
    logic [15:0]  block_timeout;

    logic [255:0] pool_name [POOL_SIZE];
    logic [5:0]   pool_len  [POOL_SIZE];
    logic [31:0]  sim_now;

    t_out_item verdict_q[$];
    t_out_item want;
    int        err_count   = 0;
    int        cycle_count = 0;

    timed_name_block_table DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_cmd          (i_cmd),
        .o_result_valid (o_result_valid),
        .o_result       (o_result),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: timeout", $time);
            $display("FAIL");
            $finish;
        end
    end

    function automatic logic [255:0] name_mask(input logic [5:0] len);
        logic [255:0] m;
        m = '0;
        for (int b = 0; b < NAME_MAX_BYTES; b++) begin
            if (b < len) begin
                m[b*8 +: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

    function automatic bit slot_is_free(input int s);
        return slot_len[s] == 6'd0 || slot_name[s][7:0] == 8'h00;
    endfunction

    // Applies one transaction to the local table and returns its verdict.
    function automatic t_out_item table_verdict(input t_in_item cmd);
        t_out_item    v;
        logic [255:0] key;
        logic [255:0] m;
        logic [5:0]   slen;
        bit           done;
        key = {cmd.name_bytes_24_31, cmd.name_bytes_16_23,
               cmd.name_bytes_8_15, cmd.name_bytes_0_7};
        v.result_code = CODE_FREE;
        v.slot_index  = '0;
        done          = 1'b0;
        if (cmd.op == OP_INSERT) begin
            v.result_code = CODE_FULL;
            slen = (cmd.name_length > 6'(NAME_MAX_BYTES)) ? 6'(NAME_MAX_BYTES)
                                                           : cmd.name_length;
            m = name_mask(slen);
            for (int s = 0; s < TABLE_SLOTS && !done; s++) begin
                if (slot_is_free(s)) begin
                    slot_name[s]   = key & m;
                    slot_len[s]    = slen;
                    slot_expiry[s] = cmd.now_seconds + {16'd0, block_timeout};
                    v.result_code  = CODE_INSERTED;
                    v.slot_index   = 4'(s);
                    done           = 1'b1;
                end
            end
        end else begin
            m = name_mask(cmd.name_length);
            for (int s = 0; s < TABLE_SLOTS && !done; s++) begin
                if (slot_expiry[s] <= cmd.now_seconds) begin
                    slot_name[s]   = '0;
                    slot_len[s]    = '0;
                    slot_expiry[s] = '0;
                end
                if (!slot_is_free(s) && cmd.name_length <= 6'(NAME_MAX_BYTES) &&
                    slot_len[s] == cmd.name_length && (slot_name[s] & m) == (key & m)) begin
                    v.result_code = CODE_BLOCKED;
                    v.slot_index  = 4'(s);
                    done          = 1'b1;
                end
            end
        end
        return v;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid === 1'b1) begin
            if (verdict_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, got code %0d slot %0d",
                         $time, o_result.result_code, o_result.slot_index);
                err_count++;
            end else begin
                want = verdict_q.pop_front();
                if (o_result.result_code !== want.result_code) begin
                    $display("%0t: result_code mismatch, expected %0d, got %0d",
                             $time, want.result_code, o_result.result_code);
                    err_count++;
                end
                if (o_result.slot_index !== want.slot_index) begin
                    $display("%0t: slot_index mismatch, expected %0d, got %0d",
                             $time, want.slot_index, o_result.slot_index);
                    err_count++;
                end
            end
        end
    end

    function automatic logic [255:0] random_bits256();
        return {$urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom, $urandom, $urandom};
    endfunction

    function automatic t_in_item make_cmd(input logic op, input logic [255:0] name,
                                          input logic [5:0] len, input logic [31:0] now);
        t_in_item c;
        c.op               = op;
        c.name_bytes_0_7   = name[63:0];
        c.name_bytes_8_15  = name[127:64];
        c.name_bytes_16_23 = name[191:128];
        c.name_bytes_24_31 = name[255:192];
        c.name_length      = len;
        c.now_seconds      = now;
        return c;
    endfunction

    task automatic send_cmd(input t_in_item cmd, input int idle_pct);
        start <= 1'b1;
        i_cmd <= cmd;
        do @(posedge i_clk); while (busy !== 1'b0);
        verdict_q.push_back(table_verdict(cmd));
        if ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
    endtask

    task automatic wait_all_verdicts();
        start <= 1'b0;
        while (verdict_q.size() != 0 || busy !== 1'b0) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic write_timeout(input logic [15:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        block_timeout = value;
        i_cfg_we    <= 1'b0;
    endtask

    task automatic test_special_names();
        logic [255:0] junk;
        logic [255:0] zero_first;
        logic [255:0] short_name;
        logic [255:0] other;
        junk        = random_bits256();
        junk[7:0]   = 8'h41;
        zero_first  = random_bits256();
        zero_first[7:0] = 8'h00;
        short_name  = {random_bits256()} & ~name_mask(6'd3) | 256'h636261;
        send_cmd(make_cmd(OP_INSERT, '1, 6'd32, 32'd1000), 0);
        send_cmd(make_cmd(OP_LOOKUP, '1, 6'd32, 32'd1000), 0);
        send_cmd(make_cmd(OP_LOOKUP, '1, 6'd63, 32'd1000), 0);
        send_cmd(make_cmd(OP_INSERT, junk, 6'd63, 32'd1000), 0);
        send_cmd(make_cmd(OP_LOOKUP, junk, 6'd32, 32'd1001), 0);
        send_cmd(make_cmd(OP_INSERT, '0, 6'd0, 32'd1000), 0);
        send_cmd(make_cmd(OP_INSERT, zero_first, 6'd5, 32'd1000), 0);
        send_cmd(make_cmd(OP_LOOKUP, '0, 6'd0, 32'd1002), 0);
        send_cmd(make_cmd(OP_LOOKUP, zero_first, 6'd5, 32'd1002), 0);
        send_cmd(make_cmd(OP_INSERT, short_name, 6'd3, 32'd1000), 0);
        for (int i = 0; i < TABLE_SLOTS - 3; i++) begin
            other      = random_bits256();
            other[7:0] = 8'($urandom_range(1, 255));
            send_cmd(make_cmd(OP_INSERT, other, 6'($urandom_range(1, 32)), 32'd1000), 0);
        end
        send_cmd(make_cmd(OP_INSERT, short_name, 6'd3, 32'd1000), 0);
        other = random_bits256() & ~name_mask(6'd3) | 256'h636261;
        send_cmd(make_cmd(OP_LOOKUP, other, 6'd3, 32'd1059), 0);
        send_cmd(make_cmd(OP_LOOKUP, other ^ 256'h040000, 6'd3, 32'd1059), 0);
        send_cmd(make_cmd(OP_LOOKUP, short_name, 6'd4, 32'd1059), 0);
        send_cmd(make_cmd(OP_LOOKUP, short_name, 6'd3, 32'd1060), 0);
        send_cmd(make_cmd(OP_INSERT, short_name, 6'd3, 32'hFFFF_FFF0), 0);
        send_cmd(make_cmd(OP_LOOKUP, short_name, 6'd3, 32'h0000_0010), 0);
        send_cmd(make_cmd(OP_LOOKUP, short_name, 6'd3, 32'hFFFF_FFFF), 0);
    endtask

    task automatic test_timeout_extremes();
        wait_all_verdicts();
        write_timeout(16'h0000);
        send_cmd(make_cmd(OP_INSERT, '1, 6'd32, 32'd500), 0);
        send_cmd(make_cmd(OP_LOOKUP, '1, 6'd32, 32'd500), 0);
        wait_all_verdicts();
        write_timeout(16'hFFFF);
        send_cmd(make_cmd(OP_INSERT, '1, 6'd32, 32'hFFFF_0000), 0);
        send_cmd(make_cmd(OP_LOOKUP, '1, 6'd32, 32'hFFFF_FFFE), 0);
        send_cmd(make_cmd(OP_INSERT, '1, 6'd8, 32'hFFFF_0001), 0);
        send_cmd(make_cmd(OP_LOOKUP, '1, 6'd8, 32'hFFFF_FFFE), 0);
        send_cmd(make_cmd(OP_LOOKUP, '1, 6'd32, 32'hFFFF_FFFF), 0);
    endtask

    task automatic test_random_traffic(input int n_items, input int idle_pct,
                                       input logic [15:0] timeout_value);
        t_in_item     cmd;
        logic [255:0] name;
        logic [5:0]   len;
        int           pick;
        int           k;
        wait_all_verdicts();
        write_timeout(timeout_value);
        for (int p = 0; p < POOL_SIZE; p++) begin
            pool_len[p]  = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(9, 32))
                                                       : 6'($urandom_range(1, 8));
            pool_name[p] = random_bits256() & name_mask(pool_len[p]);
            pool_name[p][7:0] = 8'($urandom_range(1, 255));
        end
        sim_now = $urandom_range(0, 32'h7FFF_FFFF);
        for (int i = 0; i < n_items; i++) begin
            pick    = $urandom_range(0, 99);
            k       = $urandom_range(0, POOL_SIZE - 1);
            len     = pool_len[k];
            name    = pool_name[k] | (random_bits256() & ~name_mask(len));
            sim_now = sim_now + $urandom_range(0, 4);
            if (pick < 45) begin
                cmd = make_cmd(OP_INSERT, name, len, sim_now);
            end else if (pick < 80) begin
                cmd = make_cmd(OP_LOOKUP, name, len, sim_now);
            end else if (pick < 90) begin
                if ($urandom_range(0, 1) == 1) begin
                    name[8*$urandom_range(0, len - 1) +: 8] ^= 8'($urandom_range(1, 255));
                end else begin
                    len = len ^ 6'($urandom_range(1, 3));
                end
                cmd = make_cmd(OP_LOOKUP, name, len, sim_now);
            end else begin
                cmd = make_cmd(1'($urandom_range(0, 1)), random_bits256(),
                               6'($urandom_range(0, 63)),
                               ($urandom_range(0, 1) == 1) ? $urandom : sim_now);
            end
            send_cmd(cmd, idle_pct);
        end
    endtask

    initial begin
        for (int s = 0; s < TABLE_SLOTS; s++) begin
            slot_name[s]   = '0;
            slot_len[s]    = '0;
            slot_expiry[s] = '0;
        end
        block_timeout = TIMEOUT_RESET;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_special_names();
        test_timeout_extremes();
        test_random_traffic(600, 0, 16'd40);
        test_random_traffic(600, 63, 16'($urandom_range(10, 100)));
        test_random_traffic(600, 14, 16'($urandom_range(1, 300)));

        wait_all_verdicts();
        repeat (2 * (TABLE_SLOTS + 4)) @(posedge i_clk);
        if (err_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
